>>> sv/mfa_pkg.sv
// Shared constants and operation codes for the mixed fraction ALU.
`default_nettype none
package mfa_pkg;
    localparam int PartWidth = 12;
    localparam int ResWidth  = 48;
    localparam int TypeWidth = 3;

    localparam logic [TypeWidth-1:0] OP_ADD = 3'd0;
    localparam logic [TypeWidth-1:0] OP_SUB = 3'd1;
    localparam logic [TypeWidth-1:0] OP_MUL = 3'd2;
    localparam logic [TypeWidth-1:0] OP_DIV = 3'd3;
    localparam logic [TypeWidth-1:0] OP_CMP = 3'd4;
endpackage
`default_nettype wire

>>> sv/mfa_if.sv
// Valid/ready channel interface carrying a generic payload.
`default_nettype none
interface mfa_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> sv/mfa_front.sv
// Front end: operand validation, improper fractions and cross products.
`default_nettype none
module mfa_front #(
    parameter int PW = mfa_pkg::PartWidth,
    parameter int FW = 2 * PW + 1
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [mfa_pkg::TypeWidth-1:0]  i_req_type,
    input  wire logic signed [PW-1:0]           i_a_whole,
    input  wire logic signed [PW-1:0]           i_a_num,
    input  wire logic signed [PW-1:0]           i_a_den,
    input  wire logic signed [PW-1:0]           i_b_whole,
    input  wire logic signed [PW-1:0]           i_b_num,
    input  wire logic signed [PW-1:0]           i_b_den,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [mfa_pkg::TypeWidth-1:0]       o_op,
    output logic signed [2*FW-1:0]              o_x,
    output logic signed [2*FW-1:0]              o_y,
    output logic signed [2*FW-1:0]              o_z
);
    import mfa_pkg::*;
    localparam int XW = 2 * FW;

    // Stage 1 holds the improper fractions; stage 2 holds the products.
    logic                  r_v1, r_v2;
    logic [TypeWidth-1:0]  r_op1, r_op2;
    logic signed [FW-1:0]  r_n1, r_d1, r_n2, r_d2;
    logic signed [XW-1:0]  r_x, r_y, r_z;
    logic signed [FW-1:0]  n_n1, n_d1, n_n2, n_d2;
    logic                  adv2, adv1;

    function automatic logic signed [2*FW-1:0] improper(
        input logic signed [PW-1:0] w, input logic signed [PW-1:0] n,
        input logic signed [PW-1:0] d);
        logic signed [PW-1:0] ww, nn, dd;
        logic [1:0] negs;
        logic signed [FW-1:0] num, prod;
        begin
            negs = 2'(w[PW-1]) + 2'(n[PW-1]) + 2'(d[PW-1]);
            if (d == '0 || negs > 2'd1) begin
                ww = '0; nn = '0; dd = PW'(1);
            end else begin
                ww = w; nn = n; dd = d;
            end
            prod = FW'(ww) * FW'(dd);
            if (ww[PW-1]) num = prod - FW'(nn);
            else num = prod + FW'(nn);
            improper = {num, FW'(dd)};
        end
    endfunction

    always_comb begin
        {n_n1, n_d1} = improper(i_a_whole, i_a_num, i_a_den);
        {n_n2, n_d2} = improper(i_b_whole, i_b_num, i_b_den);
    end

    assign adv2 = !r_v2 || i_ready;
    assign adv1 = !r_v1 || adv2;
    assign o_ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
        end
        if (adv1 && i_valid) begin
            r_op1 <= i_req_type;
            r_n1 <= n_n1; r_d1 <= n_d1; r_n2 <= n_n2; r_d2 <= n_d2;
        end
        if (adv2 && r_v1) begin
            r_op2 <= r_op1;
            unique case (r_op1)
                OP_MUL: begin
                    r_x <= XW'(r_n1) * XW'(r_n2);
                    r_y <= XW'(r_d1) * XW'(r_d2);
                    r_z <= '0;
                end
                OP_DIV: begin
                    r_x <= XW'(r_n1) * XW'(r_d2);
                    r_y <= XW'(r_d1) * XW'(r_n2);
                    r_z <= XW'(r_n2);
                end
                default: begin
                    r_x <= XW'(r_n1) * XW'(r_d2);
                    r_y <= XW'(r_n2) * XW'(r_d1);
                    r_z <= XW'(r_d1) * XW'(r_d2);
                end
            endcase
        end
    end

    assign o_valid = r_v2;
    assign o_op    = r_op2;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
endmodule
`default_nettype wire

>>> sv/mfa_queue.sv
// Small FIFO between front and back ends.
`default_nettype none
module mfa_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [DW-1:0] i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [DW-1:0]      o_data
);
    localparam int AW = $clog2(DEPTH);
    logic [DW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          wr, rd;

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
        if (wr) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

>>> sv/mfa_back.sv
// Back end: compare, gcd reduction by iterative division, result register.
`default_nettype none
module mfa_back #(
    parameter int XW = 50
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [mfa_pkg::TypeWidth-1:0] i_op,
    input  wire logic signed [XW-1:0]          i_x,
    input  wire logic signed [XW-1:0]          i_y,
    input  wire logic signed [XW-1:0]          i_z,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [mfa_pkg::ResWidth-1:0] o_res_num,
    output logic signed [mfa_pkg::ResWidth-1:0] o_res_den,
    output logic                               o_less,
    output logic                               o_equal,
    output logic                               o_greater,
    output logic                               o_div_zero
);
    import mfa_pkg::*;
    localparam int RW = ResWidth;
    localparam int CW = $clog2(XW + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_QN   = 3'd3;
    localparam logic [2:0] S_QD   = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]           r_state;
    logic signed [XW-1:0] r_rn, r_rd, r_gx, r_gy;
    // Unsigned restoring divider: dividend shifts into remainder one bit a cycle.
    logic [XW-1:0]        r_dvd, r_dvs, r_rem;
    logic                 r_dneg, r_nneg;
    logic [CW-1:0]        r_cnt;
    logic [XW:0]          trial;
    logic [XW-1:0]        rem_sh, ax, ay;
    logic signed [XW-1:0] sgn_rem, sgn_quo;

    assign ax = r_gx[XW-1] ? XW'(-r_gx) : XW'(r_gx);
    assign ay = r_gy[XW-1] ? XW'(-r_gy) : XW'(r_gy);
    assign rem_sh = {r_rem[XW-2:0], r_dvd[XW-1]};
    assign trial = {1'b0, rem_sh} - {1'b0, r_dvs};
    assign sgn_rem = r_nneg ? -$signed(r_rem) : $signed(r_rem);
    assign sgn_quo = (r_nneg ^ r_dneg) ? -$signed(r_dvd) : $signed(r_dvd);

    assign o_ready = r_state == S_IDLE && !o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    o_less <= 1'b0; o_equal <= 1'b0; o_greater <= 1'b0;
                    o_div_zero <= 1'b0;
                    o_res_num <= RW'(i_x); o_res_den <= RW'(i_y);
                    unique case (i_op) inside
                        OP_ADD, OP_SUB: begin
                            r_rn <= (i_op == OP_ADD) ? i_x + i_y : i_x - i_y;
                            r_gx <= (i_op == OP_ADD) ? i_x + i_y : i_x - i_y;
                            r_rd <= i_z;
                            r_gy <= i_z;
                            r_state <= S_GCD;
                        end
                        OP_MUL: o_valid <= 1'b1;
                        OP_DIV: begin
                            o_div_zero <= i_z == '0;
                            o_valid <= 1'b1;
                        end
                        OP_CMP: begin
                            o_res_num <= '0; o_res_den <= '0;
                            o_less <= i_x < i_y;
                            o_equal <= i_x == i_y;
                            o_greater <= i_x > i_y;
                            o_valid <= 1'b1;
                        end
                        default: begin
                            o_res_num <= '0; o_res_den <= '0;
                            o_valid <= 1'b1;
                        end
                    endcase
                end
                S_GCD: begin
                    if (r_gy == '0) begin
                        if (r_gx == '0) begin
                            o_res_num <= RW'(r_rn); o_res_den <= RW'(r_rd);
                            o_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_dvd <= r_rn[XW-1] ? XW'(-r_rn) : XW'(r_rn);
                            r_nneg <= r_rn[XW-1];
                            r_dvs <= ax; r_dneg <= r_gx[XW-1];
                            r_rem <= '0; r_cnt <= CW'(XW);
                            r_state <= S_QN;
                        end
                    end else begin
                        r_dvd <= ax; r_nneg <= r_gx[XW-1];
                        r_dvs <= ay; r_dneg <= r_gy[XW-1];
                        r_rem <= '0; r_cnt <= CW'(XW);
                        r_state <= S_DIV;
                    end
                end
                S_DIV, S_QN, S_QD: begin
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - 1'b1;
                        r_dvd <= {r_dvd[XW-2:0], !trial[XW]};
                        r_rem <= trial[XW] ? rem_sh : trial[XW-1:0];
                    end else if (r_state == S_DIV) begin
                        r_gx <= r_gy;
                        r_gy <= sgn_rem;
                        r_state <= S_GCD;
                    end else if (r_state == S_QN) begin
                        o_res_num <= RW'(sgn_quo);
                        r_dvd <= r_rd[XW-1] ? XW'(-r_rd) : XW'(r_rd);
                        r_nneg <= r_rd[XW-1];
                        r_rem <= '0; r_cnt <= CW'(XW);
                        r_state <= S_QD;
                    end else begin
                        o_res_den <= RW'(sgn_quo);
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> sv/mixed_fraction_alu.sv
// Path: the front stages (improper fractions, then products), the queue, then the back end,
// which registers the result directly for multiply, divide and compare; add and subtract
// run a Euclid gcd with a one-bit-per-cycle divider, then two final divisions by the gcd.
// The back end takes a new request only when idle and once its last result has been taken.
// Reset: synchronous active-low i_rst_n clears all valid flags and control state.
`default_nettype none
module mixed_fraction_alu #(
    parameter int PART_WIDTH = mfa_pkg::PartWidth
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mfa_if.sink       i_req,
    mfa_if.source     o_res
);
    import mfa_pkg::*;
    localparam int FW = 2 * PART_WIDTH + 1;
    localparam int XW = 2 * FW;
    localparam int QW = TypeWidth + 3 * XW;

    logic                 f_valid, f_ready, b_valid, b_ready;
    logic [TypeWidth-1:0] f_op, b_op;
    logic signed [XW-1:0] f_x, f_y, f_z, b_x, b_y, b_z;

    mfa_front #(.PW(PART_WIDTH), .FW(FW)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_req.valid), .o_ready(i_req.ready),
        .i_req_type(i_req.payload.req_type),
        .i_a_whole(PART_WIDTH'(i_req.payload.a_whole)),
        .i_a_num(PART_WIDTH'(i_req.payload.a_num)),
        .i_a_den(PART_WIDTH'(i_req.payload.a_den)),
        .i_b_whole(PART_WIDTH'(i_req.payload.b_whole)),
        .i_b_num(PART_WIDTH'(i_req.payload.b_num)),
        .i_b_den(PART_WIDTH'(i_req.payload.b_den)),
        .o_valid(f_valid), .i_ready(f_ready),
        .o_op(f_op), .o_x(f_x), .o_y(f_y), .o_z(f_z)
    );

    mfa_queue #(.DW(QW), .DEPTH(2)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_data({f_op, f_x, f_y, f_z}),
        .o_valid(b_valid), .i_ready(b_ready), .o_data({b_op, b_x, b_y, b_z})
    );

    mfa_back #(.XW(XW)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(b_valid), .o_ready(b_ready),
        .i_op(b_op), .i_x(b_x), .i_y(b_y), .i_z(b_z),
        .o_valid(o_res.valid), .i_ready(o_res.ready),
        .o_res_num(o_res.payload.res_num), .o_res_den(o_res.payload.res_den),
        .o_less(o_res.payload.less), .o_equal(o_res.payload.equal),
        .o_greater(o_res.payload.greater), .o_div_zero(o_res.payload.div_zero)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> $countones({o_res.payload.less, o_res.payload.equal,
                                    o_res.payload.greater}) <= 1)
        else $error("more than one compare flag set");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.payload.div_zero) |-> o_res.payload.res_den == '0)
        else $error("divide by zero with nonzero denominator");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> o_res.valid)
        else $error("result dropped while stalled");
endmodule
`default_nettype wire
